// File: rtl/frd_pkg.sv
// Shared types, constants and command/status structs for the response deframer.
package frd_pkg;

    localparam int MAX_RESPONSE_LEN = 64;
    localparam int BODY_AW = $clog2(MAX_RESPONSE_LEN);
    localparam int BODY_CW = $clog2(MAX_RESPONSE_LEN + 1);

    localparam logic [7:0]  SYNC_BYTE0    = 8'hEF;
    localparam logic [7:0]  SYNC_BYTE1    = 8'h01;
    localparam logic [7:0]  ACK_PACKET_ID = 8'h07;
    localparam logic [15:0] MIN_LEN       = 16'd3;
    localparam logic [15:0] MAX_LEN       = 16'(MAX_RESPONSE_LEN);
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    localparam logic [2:0] HDR_ID_IDX    = 3'd4;
    localparam logic [2:0] HDR_LENH_IDX  = 3'd5;
    localparam logic [2:0] HDR_LAST_IDX  = 3'd6;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_TIMEOUT  = 3'd1;
    localparam logic [2:0] STATUS_BAD_LEN  = 3'd2;
    localparam logic [2:0] STATUS_BAD_SUM  = 3'd3;
    localparam logic [2:0] STATUS_BAD_ID   = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  rx_byte;
        logic [15:0] timeout_ticks;
        logic [6:0]  data_capacity;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       is_confirm;
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_SYNC0,
        CS_SYNC1,
        CS_HEADER,
        CS_BODY,
        CS_READ,
        CS_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic       load_item;
        logic       arm;
        logic       tick;
        logic       clr_hdr;
        logic       hdr_byte;
        logic       body_byte;
        logic       emit_start;
        logic       rd_next;
        logic       out_load;
        logic       out_emit;
        logic [2:0] out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       is_sync0;
        logic       is_sync1;
        logic       hdr_last;
        logic       len_bad;
        logic       byte_timeout;
        logic       tick_timeout;
        logic       body_last;
        logic       sum_bad;
        logic       id_bad;
        logic       emit_last;
    } dp_stat_t;

endpackage

// File: rtl/fingerprint_response_deframer_top.sv
// An item is registered when it transfers and is stepped from that register; one item is held at a time.
// Error and timeout results are loaded into the result register when the item that raises them is stepped.
// After a good packet's last body byte, its confirm code and then each further byte pass through the READ
// and SEND states, set by the registered read port of the body memory; SEND waits while the result stalls.
// A waiting result holds off the next step until it transfers.
// Reset clears all control state at once; the body memory needs no clearing pass.
module fingerprint_response_deframer_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  frd_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output frd_pkg::result_t result
);

    frd_pkg::dp_cmd_t  cmd;
    frd_pkg::dp_stat_t stat;

    frd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    frd_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

// File: rtl/frd_datapath.sv
// Datapath: held item, header and body registers, body memory and result register.
module frd_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  frd_pkg::item_t    item,
    input  frd_pkg::dp_cmd_t  cmd,
    output frd_pkg::dp_stat_t stat,
    output frd_pkg::result_t  result
);

    frd_pkg::item_t   item_reg;
    frd_pkg::result_t result_reg;

    logic [15:0] elapsed_reg;
    logic [15:0] limit_reg;
    logic [6:0]  cap_reg;
    logic [2:0]  hdr_cnt_reg;
    logic [7:0]  id_reg;
    logic [15:0] len_reg;
    logic [frd_pkg::BODY_CW-1:0] body_cnt_reg;
    logic [15:0] sum_reg;
    logic [7:0]  prev_byte_reg;
    logic [frd_pkg::BODY_AW-1:0] data_cnt_reg;
    logic [frd_pkg::BODY_AW-1:0] rd_ptr_reg;
    logic [7:0]  rd_data_reg;

    logic [7:0] body_mem [frd_pkg::MAX_RESPONSE_LEN];

    logic [7:0]  rx;
    logic [15:0] elapsed_inc;
    logic [15:0] len_new;
    logic [15:0] cnt_ext;
    logic        sum_add;
    logic [15:0] payload_len;
    logic [15:0] cap_ext;
    logic [15:0] data_cnt_next;

    always_comb
    begin
        rx            = item_reg.rx_byte;
        elapsed_inc   = (elapsed_reg == frd_pkg::TICK_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
        len_new       = {len_reg[15:8], rx};
        cnt_ext       = 16'(body_cnt_reg);
        sum_add       = (cnt_ext + 16'd2) < len_reg;
        payload_len   = len_reg - frd_pkg::MIN_LEN;
        cap_ext       = 16'(cap_reg);
        data_cnt_next = (payload_len > cap_ext) ? cap_ext : payload_len;

        stat.op           = item_reg.operation;
        stat.is_sync0     = (rx == frd_pkg::SYNC_BYTE0);
        stat.is_sync1     = (rx == frd_pkg::SYNC_BYTE1);
        stat.hdr_last     = (hdr_cnt_reg == frd_pkg::HDR_LAST_IDX);
        stat.len_bad      = (len_new < frd_pkg::MIN_LEN) || (len_new > frd_pkg::MAX_LEN);
        stat.byte_timeout = (elapsed_reg >= limit_reg);
        stat.tick_timeout = (elapsed_inc >= limit_reg);
        stat.body_last    = (cnt_ext + 16'd1) >= len_reg;
        // The last two body bytes carry the expected sum, high byte first.
        stat.sum_bad      = ({prev_byte_reg, rx} != sum_reg);
        stat.id_bad       = (id_reg != frd_pkg::ACK_PACKET_ID);
        stat.emit_last    = (rd_ptr_reg == data_cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg  <= '0;
            limit_reg    <= '0;
            cap_reg      <= '0;
            hdr_cnt_reg  <= '0;
            id_reg       <= '0;
            len_reg      <= '0;
            body_cnt_reg <= '0;
            sum_reg      <= '0;
            data_cnt_reg <= '0;
            rd_ptr_reg   <= '0;
        end
        else
        begin
            if (cmd.arm)
            begin
                limit_reg    <= item_reg.timeout_ticks;
                cap_reg      <= item_reg.data_capacity;
                elapsed_reg  <= '0;
                hdr_cnt_reg  <= '0;
                id_reg       <= '0;
                len_reg      <= '0;
                body_cnt_reg <= '0;
                sum_reg      <= '0;
            end
            if (cmd.tick)
            begin
                elapsed_reg <= elapsed_inc;
            end
            if (cmd.clr_hdr)
            begin
                hdr_cnt_reg <= '0;
            end
            if (cmd.hdr_byte)
            begin
                case (hdr_cnt_reg)
                    frd_pkg::HDR_ID_IDX:   id_reg  <= rx;
                    frd_pkg::HDR_LENH_IDX: len_reg <= {rx, 8'h00};
                    frd_pkg::HDR_LAST_IDX: len_reg <= len_new;
                    default:               id_reg  <= id_reg;
                endcase
                if (stat.hdr_last)
                begin
                    hdr_cnt_reg  <= '0;
                    sum_reg      <= 16'(id_reg) + 16'(len_reg[15:8]) + 16'(rx);
                    body_cnt_reg <= '0;
                end
                else
                begin
                    hdr_cnt_reg <= hdr_cnt_reg + 3'd1;
                end
            end
            if (cmd.body_byte)
            begin
                if (sum_add)
                begin
                    sum_reg <= sum_reg + 16'(rx);
                end
                body_cnt_reg <= body_cnt_reg + frd_pkg::BODY_CW'(1);
            end
            if (cmd.emit_start)
            begin
                rd_ptr_reg   <= '0;
                data_cnt_reg <= frd_pkg::BODY_AW'(data_cnt_next);
            end
            if (cmd.rd_next)
            begin
                rd_ptr_reg <= rd_ptr_reg + frd_pkg::BODY_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.body_byte)
        begin
            prev_byte_reg <= rx;
            body_mem[body_cnt_reg[frd_pkg::BODY_AW-1:0]] <= rx;
        end
        rd_data_reg <= body_mem[rd_ptr_reg];
        if (cmd.out_load)
        begin
            if (cmd.out_emit)
            begin
                result_reg.status     <= frd_pkg::STATUS_OK;
                result_reg.is_confirm <= (rd_ptr_reg == '0);
                result_reg.out_byte   <= rd_data_reg;
                result_reg.last       <= stat.emit_last;
            end
            else
            begin
                result_reg.status     <= cmd.out_status;
                result_reg.is_confirm <= 1'b0;
                result_reg.out_byte   <= 8'h00;
                result_reg.last       <= 1'b1;
            end
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/frd_ctrl.sv
// Controller: framing state machine, item and result handshakes.
module frd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    input  frd_pkg::dp_stat_t stat,
    output frd_pkg::dp_cmd_t  cmd
);

    frd_pkg::ctrl_state_t state_reg;
    frd_pkg::ctrl_state_t state_next;
    logic item_valid_reg;
    logic item_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= frd_pkg::CS_IDLE;
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        item_valid_next = item_valid_reg;
        cmd             = '0;
        out_free        = !out_valid_reg || !result_stall;
        proc            = item_valid_reg && out_free &&
                          (state_reg != frd_pkg::CS_READ) && (state_reg != frd_pkg::CS_SEND);

        // One item is held at a time; it is released once its step has run.
        if (item_valid && !item_valid_reg)
        begin
            cmd.load_item   = 1'b1;
            item_valid_next = 1'b1;
        end

        case (state_reg)
            frd_pkg::CS_READ:
            begin
                state_next = frd_pkg::CS_SEND;
            end
            frd_pkg::CS_SEND:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_emit = 1'b1;
                    if (stat.emit_last)
                    begin
                        state_next = frd_pkg::CS_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = frd_pkg::CS_READ;
                    end
                end
            end
            default:
            begin
                if (proc)
                begin
                    item_valid_next = 1'b0;
                    if (stat.op == frd_pkg::OP_START)
                    begin
                        cmd.arm    = 1'b1;
                        state_next = frd_pkg::CS_SYNC0;
                    end
                    else if (state_reg == frd_pkg::CS_IDLE)
                    begin
                        state_next = frd_pkg::CS_IDLE;
                    end
                    else if (stat.op == frd_pkg::OP_TICK)
                    begin
                        cmd.tick = 1'b1;
                        if (stat.tick_timeout)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = frd_pkg::STATUS_TIMEOUT;
                            state_next     = frd_pkg::CS_IDLE;
                        end
                    end
                    else if (stat.op == frd_pkg::OP_BYTE)
                    begin
                        if (stat.byte_timeout)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = frd_pkg::STATUS_TIMEOUT;
                            state_next     = frd_pkg::CS_IDLE;
                        end
                        else
                        begin
                            case (state_reg)
                                frd_pkg::CS_SYNC0:
                                begin
                                    if (stat.is_sync0)
                                    begin
                                        state_next = frd_pkg::CS_SYNC1;
                                    end
                                end
                                frd_pkg::CS_SYNC1:
                                begin
                                    // A wrong second marker byte is dropped, even 0xEF.
                                    cmd.clr_hdr = 1'b1;
                                    state_next  = stat.is_sync1 ? frd_pkg::CS_HEADER
                                                                : frd_pkg::CS_SYNC0;
                                end
                                frd_pkg::CS_HEADER:
                                begin
                                    cmd.hdr_byte = 1'b1;
                                    if (stat.hdr_last)
                                    begin
                                        if (stat.len_bad)
                                        begin
                                            cmd.out_load   = 1'b1;
                                            cmd.out_status = frd_pkg::STATUS_BAD_LEN;
                                            state_next     = frd_pkg::CS_IDLE;
                                        end
                                        else
                                        begin
                                            state_next = frd_pkg::CS_BODY;
                                        end
                                    end
                                end
                                frd_pkg::CS_BODY:
                                begin
                                    cmd.body_byte = 1'b1;
                                    if (stat.body_last)
                                    begin
                                        if (stat.sum_bad)
                                        begin
                                            cmd.out_load   = 1'b1;
                                            cmd.out_status = frd_pkg::STATUS_BAD_SUM;
                                            state_next     = frd_pkg::CS_IDLE;
                                        end
                                        else if (stat.id_bad)
                                        begin
                                            cmd.out_load   = 1'b1;
                                            cmd.out_status = frd_pkg::STATUS_BAD_ID;
                                            state_next     = frd_pkg::CS_IDLE;
                                        end
                                        else
                                        begin
                                            cmd.emit_start = 1'b1;
                                            state_next     = frd_pkg::CS_READ;
                                        end
                                    end
                                end
                                default:
                                begin
                                    state_next = state_reg;
                                end
                            endcase
                        end
                    end
                end
            end
        endcase

        out_valid_next = cmd.out_load || (out_valid_reg && result_stall);
    end

    assign item_stall   = item_valid_reg;
    assign result_valid = out_valid_reg;

    // A result is never written over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !result_stall))
        else $error("result register overwritten while stalled");

    // An error result always ends the response.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !cmd.out_emit) |=> (state_reg == frd_pkg::CS_IDLE))
        else $error("error result did not return to idle");

    // Arming consumes the held item and starts the marker hunt.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.arm |=> (!item_valid_reg && (state_reg == frd_pkg::CS_SYNC0)))
        else $error("start did not re-arm the hunt");

    // Buffered results are never sent while an item is being stepped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_emit) |-> !(cmd.body_byte || cmd.hdr_byte || cmd.arm || cmd.tick))
        else $error("emit overlapped with item processing");

endmodule
